// ----- hw/rtl/full_linear_convolution_1d_defines.svh -----
// ----------------------------------------------------------------------------
// full_linear_convolution_1d_defines.svh
// Assertion macros shared by the convolution block.
// ----------------------------------------------------------------------------
`ifndef FULL_LINEAR_CONVOLUTION_1D_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_1D_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/flc_pkg.sv -----
// ----------------------------------------------------------------------------
// flc_pkg
// Widths, config codes, reset values and helpers of the convolution block.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int MAX_TAPS    = 6;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int ACC_W       = 34;
    localparam int NPAIR       = (MAX_TAPS + 1) / 2;
    localparam int TAP_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST = 3'd1;

    localparam logic [TAP_W-1:0] TAP_COUNT_RST = 3'd3;

    // Issue control from the sequencer to the cell row
    typedef struct packed {
        logic shift;   // an item enters the row this cycle
        logic fresh;   // start of a new sequence: history reads as zero
        logic flush;   // tail item: the head sample is zero
    } flc_issue_t;

    // Reset value of coefficient j
    function automatic logic signed [COEF_W-1:0] coef_reset(input int idx);
        logic signed [COEF_W-1:0] val;
        case (idx)
            0:       val = 16'sd8192;
            1:       val = 16'sd16384;
            2:       val = 16'sd8192;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Tap count clamped to 1..MAX_TAPS
    function automatic logic [TAP_W-1:0] eff_taps(input logic [TAP_W-1:0] cnt);
        logic [TAP_W-1:0] val;
        if (cnt == '0)
        begin
            val = TAP_W'(1);
        end
        else if (int'(cnt) > MAX_TAPS)
        begin
            val = TAP_W'(MAX_TAPS);
        end
        else
        begin
            val = cnt;
        end
        return val;
    endfunction

endpackage

// ----- hw/rtl/flc_cell.sv -----
// ----------------------------------------------------------------------------
// flc_cell
// One tap: holds one sample of the window, hands it to its neighbor on each
// shift, and registers its coefficient product.
// ----------------------------------------------------------------------------
module flc_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic signed [flc_pkg::SAMPLE_W-1:0] shift_in,
    input  logic                                load,
    input  logic                                tap_on,
    input  logic signed [flc_pkg::COEF_W-1:0]   coef,
    output logic signed [flc_pkg::SAMPLE_W-1:0] win,
    output logic signed [flc_pkg::PROD_W-1:0]   prod
);
    import flc_pkg::*;

    logic signed [SAMPLE_W-1:0] win_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    // Window sample, shifted along the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift)
        begin
            win_reg <= shift_in;
        end
    end

    // Product of this tap; zero when the tap is not in use
    always_comb
    begin
        prod_next = tap_on ? (PROD_W'(coef) * PROD_W'(win_reg)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign win  = win_reg;
    assign prod = prod_reg;

endmodule

// ----- hw/rtl/flc_seq.sv -----
// ----------------------------------------------------------------------------
// flc_seq
// Issue sequencer: takes input items, inserts the zero tail items after the
// final sample of a sequence and tracks the first pipeline stage.
// ----------------------------------------------------------------------------
module flc_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tlast,
    output logic                          s_tready,
    input  logic [flc_pkg::TAP_W-1:0]     taps,
    input  logic                          adv,
    output flc_pkg::flc_issue_t           issue,
    output logic                          s0_valid,
    output logic                          s0_last
);
    import flc_pkg::*;

    logic             flush_reg,  flush_next;
    logic [TAP_W-1:0] remain_reg, remain_next;
    logic             fresh_reg,  fresh_next;
    logic             v0_reg,     v0_next;
    logic             last0_reg,  last0_next;

    logic issue_ok;
    logic accept;
    logic flush_item;
    logic item_last;

    // Handshake and issue decisions
    always_comb
    begin
        issue_ok   = !v0_reg || adv;
        s_tready   = issue_ok && !flush_reg;
        accept     = s_tvalid && s_tready;
        flush_item = issue_ok && flush_reg;
        item_last  = flush_item ? (remain_reg == TAP_W'(1))
                                : (s_tlast && (taps == TAP_W'(1)));

        issue.shift = accept || flush_item;
        issue.fresh = fresh_reg;
        issue.flush = flush_reg;
    end

    // Next state
    always_comb
    begin
        flush_next  = flush_reg;
        remain_next = remain_reg;
        fresh_next  = fresh_reg;
        v0_next     = v0_reg;
        last0_next  = last0_reg;

        if (flush_item)
        begin
            remain_next = remain_reg - TAP_W'(1);
            if (remain_reg == TAP_W'(1))
            begin
                flush_next = 1'b0;
            end
        end

        if (accept && s_tlast && (taps != TAP_W'(1)))
        begin
            flush_next  = 1'b1;
            remain_next = taps - TAP_W'(1);
        end

        if (issue.shift)
        begin
            fresh_next = item_last;
            v0_next    = 1'b1;
            last0_next = item_last;
        end
        else if (adv)
        begin
            v0_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg  <= 1'b0;
            remain_reg <= '0;
            fresh_reg  <= 1'b1;
            v0_reg     <= 1'b0;
            last0_reg  <= 1'b0;
        end
        else
        begin
            flush_reg  <= flush_next;
            remain_reg <= remain_next;
            fresh_reg  <= fresh_next;
            v0_reg     <= v0_next;
            last0_reg  <= last0_next;
        end
    end

    assign s0_valid = v0_reg;
    assign s0_last  = last0_reg;

endmodule

// ----- hw/rtl/flc_sum.sv -----
// ----------------------------------------------------------------------------
// flc_sum
// Two-stage registered adder tree over the tap products, ending in the
// output register of the result channel.
// ----------------------------------------------------------------------------
module flc_sum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [flc_pkg::PROD_W-1:0] prod [flc_pkg::MAX_TAPS],
    input  logic                              in_valid,
    input  logic                              in_last,
    output logic                              in_ready,
    output logic                              out_valid,
    output logic signed [flc_pkg::ACC_W-1:0]  out_value,
    output logic                              out_last,
    input  logic                              out_ready
);
    import flc_pkg::*;

    logic signed [PROD_W-1:0] prod_pad [2*NPAIR];
    logic signed [PAIR_W-1:0] pair_reg [NPAIR];
    logic signed [PAIR_W-1:0] pair_next [NPAIR];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic v2_reg, last2_reg;
    logic v3_reg, last3_reg;
    logic r2, r3;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign in_ready = r2;

    // First level: pairwise sums
    always_comb
    begin
        for (int i = 0; i < 2*NPAIR; i++)
        begin
            prod_pad[i] = (i < MAX_TAPS) ? prod[i] : '0;
        end
        for (int p = 0; p < NPAIR; p++)
        begin
            pair_next[p] = PAIR_W'(prod_pad[2*p]) + PAIR_W'(prod_pad[2*p+1]);
        end
    end

    // Second level: sum of the pairs
    always_comb
    begin
        acc_next = '0;
        for (int p = 0; p < NPAIR; p++)
        begin
            acc_next = acc_next + ACC_W'(pair_reg[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            pair_reg <= pair_next;
        end
        if (r3)
        begin
            acc_reg <= acc_next;
        end
    end

    // Stage valid and last flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
            v3_reg    <= 1'b0;
            last3_reg <= 1'b0;
        end
        else
        begin
            if (r2)
            begin
                v2_reg    <= in_valid;
                last2_reg <= in_last;
            end
            if (r3)
            begin
                v3_reg    <= v2_reg;
                last3_reg <= last2_reg;
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_value = acc_reg;
    assign out_last  = last3_reg;

endmodule

// ----- hw/rtl/full_linear_convolution_1d.sv -----
// ----------------------------------------------------------------------------
// full_linear_convolution_1d
// Full linear convolution of a signed 16-bit sample stream with up to six
// Q2.14 coefficients, exact 34-bit results.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on s_tdata; s_tlast marks the final sample of a sequence.
//   Each sample yields one result on m_tdata; the final sample yields
//   tap_count results (the tail of the convolution), the last with m_tlast.
//   The history then reads as zero for the next sequence.
//   A result is valid in m_tdata once its item has passed the window register,
//   product register, pair sums register and output register.
//   Throughput: one item per cycle while m_tready does not stall; after a
//   final sample the input is held off while the row issues the zero tail items.
//   A stall on m_tready backs up the four stages; s_tready stays high as long
//   as a stage is empty and no zero tail items are being issued.
//   Reset clears the history and loads tap_count 3 and coefficients
//   8192, 16384, 8192, 0, 0, 0. Write cfg_index/cfg_data with cfg_we only
//   while no item is in flight; index 0 is tap_count, 1..6 are coef_0..coef_5.
// ----------------------------------------------------------------------------
`include "full_linear_convolution_1d_defines.svh"

module full_linear_convolution_1d (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [flc_pkg::IN_TDATA_W-1:0]       s_tdata,   // [15:0] sample
    input  logic                                 s_tlast,   // end_of_sequence
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [flc_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [33:0] conv_value, zero fill
    output logic                                 m_tlast,   // last_result
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [flc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [flc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import flc_pkg::*;

    logic [TAP_W-1:0]         tap_count_reg;
    logic signed [COEF_W-1:0] coef_reg [MAX_TAPS];
    logic [TAP_W-1:0]         taps_eff;

    flc_issue_t               issue;
    logic                     s0_valid, s0_last;
    logic                     v1_reg, last1_reg;
    logic                     r1, r2;

    logic signed [SAMPLE_W-1:0] win_q    [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] shift_in [MAX_TAPS];
    logic signed [PROD_W-1:0]   prod_q   [MAX_TAPS];
    logic [MAX_TAPS-1:0]        tap_on;
    logic signed [ACC_W-1:0]    sum_value;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RST;
            for (int j = 0; j < MAX_TAPS; j++)
            begin
                coef_reg[j] <= coef_reset(j);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[TAP_W-1:0];
            end
            for (int j = 0; j < MAX_TAPS; j++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(CFG_COEF_FIRST) + j))
                begin
                    coef_reg[j] <= cfg_data[COEF_W-1:0];
                end
            end
        end
    end

    assign taps_eff = eff_taps(tap_count_reg);

    // Issue sequencer
    flc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .taps     (taps_eff),
        .adv      (r1),
        .issue    (issue),
        .s0_valid (s0_valid),
        .s0_last  (s0_last)
    );

    // Product stage control
    assign r1 = !v1_reg || r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
        end
        else if (r1)
        begin
            v1_reg    <= s0_valid;
            last1_reg <= s0_last;
        end
    end

    // Row of tap cells; a new sequence shifts in zeros behind the head
    always_comb
    begin
        shift_in[0] = issue.flush ? '0 : s_tdata[SAMPLE_W-1:0];
        for (int j = 1; j < MAX_TAPS; j++)
        begin
            shift_in[j] = issue.fresh ? '0 : win_q[j-1];
        end
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            tap_on[j] = TAP_W'(j) < taps_eff;
        end
    end

    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        flc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (issue.shift),
            .shift_in (shift_in[j]),
            .load     (r1),
            .tap_on   (tap_on[j]),
            .coef     (coef_reg[j]),
            .win      (win_q[j]),
            .prod     (prod_q[j])
        );
    end

    // Adder tree and output register
    flc_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod      (prod_q),
        .in_valid  (v1_reg),
        .in_last   (last1_reg),
        .in_ready  (r2),
        .out_valid (m_tvalid),
        .out_value (sum_value),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(OUT_TDATA_W-ACC_W){1'b0}}, sum_value};

    // Checks
    `FLC_ASSERT_SAME(a_no_take_in_tail, issue.flush, !s_tready,
        "input taken while tail items are issued")
    `FLC_ASSERT_NEXT(a_tail_after_final, s_tvalid && s_tready && s_tlast && (taps_eff != TAP_W'(1)), issue.flush,
        "final sample did not start the tail")
    `FLC_ASSERT_NEXT(a_fresh_clears, issue.shift && issue.fresh, win_q[1] == '0,
        "history not cleared at start of sequence")
    `FLC_ASSERT_NEXT(a_tail_zero_head, issue.shift && issue.flush, win_q[0] == '0,
        "tail item entered with a nonzero head sample")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for full_linear_convolution_1d. Sample sequences go in
// on the input stream with random gaps, results are taken with random
// backpressure, and every result is compared against a bit-exact convolution
// predictor that runs as each item is accepted. The kernel setup is changed
// between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import flc_pkg::*;

    // Register index that maps to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       eos;
    } conv_item_t;

    typedef struct {
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } conv_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;     // [15:0] sample
    logic                    s_tlast = 1'b0;   // end_of_sequence
    logic                    m_tvalid;
    logic                    m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0]  m_tdata;          // [33:0] conv_value, zero fill
    logic                    m_tlast;          // last_result
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    conv_item_t   pending_samples[$];
    conv_result_t conv_expected[$];
    int           mismatch_count = 0;

    // Predictor copy of the kernel setup and the delay line
    logic [TAP_W-1:0]         tap_setting = 3'd3;
    logic signed [COEF_W-1:0] coef_setting [MAX_TAPS] = '{16'sd8192, 16'sd16384, 16'sd8192,
                                                          16'sd0, 16'sd0, 16'sd0};
    logic signed [SAMPLE_W-1:0] sample_hist [MAX_TAPS-1] = '{default: '0};

    // Idle counters of both sides
    int send_wait = 0;
    int send_run = 0;
    int recv_wait = 0;
    int recv_run = 0;

    full_linear_convolution_1d uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Tap count as the block uses it: zero means one, above max clamps
    function automatic int active_taps(input logic [TAP_W-1:0] cnt);
        int taps;
        taps = int'(cnt);
        if (taps < 1)
        begin
            taps = 1;
        end
        if (taps > MAX_TAPS)
        begin
            taps = MAX_TAPS;
        end
        return taps;
    endfunction

    // Expected results of one accepted sample; the final one flushes the tail
    function automatic void predict_conv(input logic signed [SAMPLE_W-1:0] smp,
                                         input logic eos);
        logic signed [SAMPLE_W-1:0] win [MAX_TAPS];
        int           taps;
        int           n_out;
        longint       acc;
        conv_result_t res;
        taps = active_taps(tap_setting);
        win[0] = smp;
        for (int k = 1; k < MAX_TAPS; k++)
        begin
            win[k] = sample_hist[k-1];
        end
        n_out = eos ? taps : 1;
        for (int t = 0; t < n_out; t++)
        begin
            acc = 0;
            for (int j = t; j < taps; j++)
            begin
                acc += longint'(coef_setting[j]) * longint'(win[j-t]);
            end
            res.value = acc[ACC_W-1:0];
            res.last = eos && (t == n_out - 1);
            conv_expected.push_back(res);
        end
        // Delay line: cleared after a sequence, else shifted
        if (eos)
        begin
            sample_hist = '{default: '0};
        end
        else
        begin
            for (int k = MAX_TAPS - 2; k > 0; k--)
            begin
                sample_hist[k] = sample_hist[k-1];
            end
            sample_hist[0] = smp;
        end
    endfunction

    // Idle cycles before the next item, with occasional runs of none
    function automatic int draw_wait(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void push_item(input logic signed [SAMPLE_W-1:0] smp, input logic eos);
        conv_item_t itm;
        itm.sample = smp;
        itm.eos = eos;
        pending_samples.push_back(itm);
    endfunction

    // One sequence of random samples, closed or left open
    function automatic void push_sequence(input int len, input bit close);
        for (int i = 0; i < len; i++)
        begin
            push_item(pick_value(), close && (i == len - 1));
        end
    endfunction

    // Register write; the predictor takes the new setup at once
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_TAP_COUNT)
        begin
            tap_setting = data[TAP_W-1:0];
        end
        else if (idx != CFG_UNUSED)
        begin
            coef_setting[idx - CFG_COEF_FIRST] = data;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, plus the pipe depth
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || conv_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        conv_item_t next_item;
        logic       accepted;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            accepted = s_tvalid && s_tready;
            if (accepted)
            begin
                predict_conv(s_tdata[SAMPLE_W-1:0], s_tlast);
                send_wait = draw_wait(send_run);
            end
            if (accepted || !s_tvalid)
            begin
                if (send_wait > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_wait--;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_item = pending_samples.pop_front();
                    s_tdata <= next_item.sample;
                    s_tlast <= next_item.eos;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        conv_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b1;
            recv_wait = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (conv_expected.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got %0d last %0b",
                         $time, $signed(m_tdata[ACC_W-1:0]), m_tlast);
            end
            else
            begin
                want = conv_expected.pop_front();
                if (m_tdata[ACC_W-1:0] !== want.value)
                begin
                    mismatch_count++;
                    $display("%0t: conv_value expected %0d, got %0d",
                             $time, want.value, $signed(m_tdata[ACC_W-1:0]));
                end
                if (m_tlast !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last_result expected %0b, got %0b",
                             $time, want.last, m_tlast);
                end
            end
            recv_wait = draw_wait(recv_run);
            if (recv_wait > 0)
            begin
                m_tready <= 1'b0;
            end
        end
        else if (!m_tready)
        begin
            recv_wait--;
            if (recv_wait <= 0)
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        int tap_pick;
        int fill;
        int len;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset kernel: field extremes, a one-sample sequence, an open tail
        @(negedge clk);
        push_item(16'sh7FFF, 1'b0);
        push_item(16'sh8000, 1'b0);
        push_item(16'shFFFF, 1'b0);
        push_item(16'sh0001, 1'b1);
        push_item(16'sh8000, 1'b1);
        push_item(16'sh3039, 1'b0);
        wait_drained();

        // Six taps of the most negative coefficient; full-length sequences of both extremes
        cfg_write(CFG_TAP_COUNT, 16'd6);
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            cfg_write(CFG_IDX_W'(int'(CFG_COEF_FIRST) + j), 16'h8000);
        end
        @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            push_item(16'sh8000, i == 5);
        end
        for (int i = 0; i < 6; i++)
        begin
            push_item(16'sh7FFF, i == 5);
        end
        wait_drained();

        // Zero tap count acts as one tap; upper data bits are don't-care
        cfg_write(CFG_TAP_COUNT, 16'hFFF8);
        cfg_write(CFG_COEF_FIRST, 16'h7FFF);
        @(negedge clk);
        push_item(16'sh8000, 1'b0);
        push_item(16'sh7FFF, 1'b1);
        wait_drained();

        // Tap count above the maximum clamps; unused index is ignored
        cfg_write(CFG_TAP_COUNT, 16'h0007);
        cfg_write(CFG_UNUSED, 16'hA5A5);
        @(negedge clk);
        push_item(16'sh1234, 1'b0);
        push_item(16'shEDCB, 1'b0);
        push_item(16'sh7FFF, 1'b1);
        wait_drained();

        // Random kernels, each with a batch of random sequences
        for (int p = 0; p < 8; p++)
        begin
            tap_pick = (p == 0) ? 1 : (p == 1) ? MAX_TAPS : $urandom_range(0, 7);
            cfg_write(CFG_TAP_COUNT, {13'($urandom), 3'(tap_pick)});
            for (int j = 0; j < MAX_TAPS; j++)
            begin
                cfg_write(CFG_IDX_W'(int'(CFG_COEF_FIRST) + j), pick_value());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                cfg_write(CFG_UNUSED, 16'($urandom));
            end
            @(negedge clk);
            fill = 0;
            while (fill < 50)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
                push_sequence(len, (fill + len < 50) || ($urandom_range(0, 1) == 1));
                fill += len;
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
